// ===== hw/rtl/servo_repeat_sequencer_assert.svh =====
// Assertion macros for the servo repeat sequencer.
// Included by the modules that check their own logic; needs nothing else.
`ifndef SERVO_REPEAT_SEQUENCER_ASSERT_SVH
`define SERVO_REPEAT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SRS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("srs assertion failed");

// next-cycle implication
`define SRS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("srs assertion failed");

`endif

// ===== hw/rtl/srs_pkg.sv =====
// Shared types and constants of the servo repeat sequencer.
// Used by srs_cfg, srs_core and servo_repeat_sequencer; depends on nothing.
package srs_pkg;

  localparam int NUM_MOTORS_DEF = 3;
  localparam int COUNT_BITS_DEF = 8;
  localparam int IN_COUNTS      = 3;
  localparam int WIDTH_BITS     = 15;
  localparam int MS_BITS        = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [WIDTH_BITS-1:0] STARTUP_WIDTH = 15'd499;
  localparam logic [WIDTH_BITS-1:0] REST_DEF      = 15'd500;
  localparam logic [WIDTH_BITS-1:0] PUSH_DEF      = 15'd1500;
  localparam logic [MS_BITS-1:0]    SETTLE_DEF    = 16'd1000;
  localparam logic [MS_BITS-1:0]    HOLD_DEF      = 16'd2000;
  localparam logic [MS_BITS-1:0]    END_DEF       = 16'd1000;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REST_WIDTH = 3'd0,
    CFG_PUSH_WIDTH = 3'd1,
    CFG_SETTLE_MS  = 3'd2,
    CFG_HOLD_MS    = 3'd3,
    CFG_END_MS     = 3'd4
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_SET_REST    = 6'b000001,
    PH_WAIT_SETTLE = 6'b000010,
    PH_SET_PUSH    = 6'b000100,
    PH_WAIT_HOLD   = 6'b001000,
    PH_SET_END     = 6'b010000,
    PH_WAIT_END    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] rest_width;
    logic [WIDTH_BITS-1:0] push_width;
    logic [MS_BITS-1:0]    settle_ms;
    logic [MS_BITS-1:0]    hold_ms;
    logic [MS_BITS-1:0]    end_ms;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] count_first;
    logic [7:0] count_second;
    logic [7:0] count_third;
  } item_t;

  // packed so that width_one sits in the lowest bits
  typedef struct packed {
    logic [7:0]            reps_done;
    logic [1:0]            motor_now;
    logic                  busy_res;
    logic [WIDTH_BITS-1:0] width_three;
    logic [WIDTH_BITS-1:0] width_two;
    logic [WIDTH_BITS-1:0] width_one;
  } res_t;

endpackage

// ===== hw/rtl/servo_repeat_sequencer.sv =====
// Servo repeat sequencer: one result item per accepted input item.
// Result: registered, and valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless m_axis_tready stalls; the output reloads while taken.
// Reset (rst, synchronous): sequencer idle, configuration at defaults, widths 499.
// Depends on srs_pkg, srs_cfg, srs_core and the assertion macros header.
`include "servo_repeat_sequencer_assert.svh"

module servo_repeat_sequencer #(
  parameter int NUM_MOTORS = srs_pkg::NUM_MOTORS_DEF,
  parameter int COUNT_BITS = srs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // count_first, count_second, count_third
  input  logic [0:0]                          s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [55:0]                         m_axis_tdata,  // width_one, width_two, width_three,
                                                             // busy_res, motor_now, reps_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [srs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  srs_pkg::cfg_t  cfg;
  srs_pkg::item_t item;
  srs_pkg::res_t  res;
  logic           accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item.op           = srs_pkg::op_t'(s_axis_tuser[0]);
  assign item.count_first  = s_axis_tdata[7:0];
  assign item.count_second = s_axis_tdata[15:8];
  assign item.count_third  = s_axis_tdata[23:16];

  srs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  srs_core #(
    .NUM_MOTORS (NUM_MOTORS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= res;
    end
  end

  `SRS_ASSERT_IMPL(a_stall_blocks, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `SRS_ASSERT_NEXT(a_accept_shows, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
  `SRS_ASSERT_NEXT(a_idle_drains, clk, rst, !accept && m_axis_tready, !m_axis_tvalid)

endmodule

// ===== hw/rtl/srs_cfg.sv =====
// Configuration register file of the servo repeat sequencer.
// Depends on srs_pkg for the register indexes and the cfg_t bundle.
module srs_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [srs_pkg::CFG_IDX_BITS-1:0]       wr_index,
  input  logic [srs_pkg::CFG_DATA_BITS-1:0]      wr_data,
  output srs_pkg::cfg_t                          cfg
);

  srs_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rest_width <= srs_pkg::REST_DEF;
      regs.push_width <= srs_pkg::PUSH_DEF;
      regs.settle_ms  <= srs_pkg::SETTLE_DEF;
      regs.hold_ms    <= srs_pkg::HOLD_DEF;
      regs.end_ms     <= srs_pkg::END_DEF;
    end else if (wr_en) begin
      unique case (srs_pkg::cfg_idx_t'(wr_index))
        srs_pkg::CFG_REST_WIDTH: regs.rest_width <= wr_data[srs_pkg::WIDTH_BITS-1:0];
        srs_pkg::CFG_PUSH_WIDTH: regs.push_width <= wr_data[srs_pkg::WIDTH_BITS-1:0];
        srs_pkg::CFG_SETTLE_MS:  regs.settle_ms  <= wr_data;
        srs_pkg::CFG_HOLD_MS:    regs.hold_ms    <= wr_data;
        srs_pkg::CFG_END_MS:     regs.end_ms     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/srs_core.sv =====
// Sequencer state and its one-item update for the servo repeat sequencer.
// Depends on srs_pkg and the assertion macros header.
`include "servo_repeat_sequencer_assert.svh"

module srs_core #(
  parameter int NUM_MOTORS = srs_pkg::NUM_MOTORS_DEF,
  parameter int COUNT_BITS = srs_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  srs_pkg::item_t item,
  input  srs_pkg::cfg_t  cfg,
  output srs_pkg::res_t  res
);

  localparam int SEL_BITS = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic                          running, running_next;
  logic [SEL_BITS-1:0]           sel, sel_next;
  srs_pkg::phase_t               phase, phase_next;
  logic [srs_pkg::MS_BITS-1:0]   elapsed, elapsed_next;
  logic [COUNT_BITS-1:0]         done, done_next;
  logic [COUNT_BITS-1:0]         target [NUM_MOTORS];
  logic [COUNT_BITS-1:0]         target_next [NUM_MOTORS];
  logic [srs_pkg::WIDTH_BITS-1:0] widths [NUM_MOTORS];
  logic [srs_pkg::WIDTH_BITS-1:0] widths_next [NUM_MOTORS];
  logic [COUNT_BITS-1:0]         cnt_in [NUM_MOTORS];
  logic [7:0]                    cnt_field [srs_pkg::IN_COUNTS];
  logic [srs_pkg::WIDTH_BITS-1:0] wout [srs_pkg::IN_COUNTS];

  logic [COUNT_BITS-1:0]         tgt_sel;
  logic [COUNT_BITS-1:0]         done_inc;
  logic [srs_pkg::MS_BITS-1:0]   elapsed_inc;
  logic [srs_pkg::MS_BITS-1:0]   wait_limit;
  logic                          wait_over;
  logic                          start_found, nxt_found;
  logic [SEL_BITS-1:0]           start_sel, nxt_sel;
  logic                          wr_cur, wr_alt;
  logic [SEL_BITS-1:0]           alt_idx;
  logic [srs_pkg::WIDTH_BITS-1:0] cur_val;

  assign cnt_field[0] = item.count_first;
  assign cnt_field[1] = item.count_second;
  assign cnt_field[2] = item.count_third;

  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_cnt
    if (g < srs_pkg::IN_COUNTS) begin : g_used
      assign cnt_in[g] = COUNT_BITS'(cnt_field[g]);
    end else begin : g_none
      assign cnt_in[g] = '0;
    end
  end

  assign tgt_sel     = target[sel];
  assign done_inc    = done + 1'b1;
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign wait_over   = (elapsed_inc >= wait_limit);

  always_comb begin
    unique case (phase)
      srs_pkg::PH_WAIT_SETTLE: wait_limit = cfg.settle_ms;
      srs_pkg::PH_WAIT_HOLD:   wait_limit = cfg.hold_ms;
      default:                 wait_limit = cfg.end_ms;
    endcase
  end

  always_comb begin
    start_found = 1'b0;
    start_sel   = '0;
    for (int k = NUM_MOTORS - 1; k >= 0; k--) begin
      if (cnt_in[k] != '0) begin
        start_found = 1'b1;
        start_sel   = SEL_BITS'(k);
      end
    end
  end

  always_comb begin
    nxt_found = 1'b0;
    nxt_sel   = '0;
    for (int k = NUM_MOTORS - 1; k >= 0; k--) begin
      if (SEL_BITS'(k) > sel && target[k] != '0) begin
        nxt_found = 1'b1;
        nxt_sel   = SEL_BITS'(k);
      end
    end
  end

  always_comb begin
    running_next = running;
    sel_next     = sel;
    phase_next   = phase;
    elapsed_next = elapsed;
    done_next    = done;
    target_next  = target;
    wr_cur       = 1'b0;
    wr_alt       = 1'b0;
    alt_idx      = nxt_sel;
    cur_val      = cfg.rest_width;
    if (step) begin
      if (item.op == srs_pkg::OP_START) begin
        target_next  = cnt_in;
        done_next    = '0;
        phase_next   = srs_pkg::PH_SET_REST;
        running_next = start_found;
        if (start_found) begin
          sel_next = start_sel;
        end
      end else if (running) begin
        if (done >= tgt_sel) begin
          wr_cur = 1'b1;
          if (!nxt_found) begin
            running_next = 1'b0;
          end else begin
            wr_alt       = 1'b1;
            sel_next     = nxt_sel;
            done_next    = '0;
            elapsed_next = '0;
            phase_next   = srs_pkg::PH_WAIT_SETTLE;
          end
        end else begin
          unique case (phase)
            srs_pkg::PH_SET_REST: begin
              wr_cur       = 1'b1;
              elapsed_next = '0;
              phase_next   = srs_pkg::PH_WAIT_SETTLE;
            end
            srs_pkg::PH_WAIT_SETTLE: begin
              elapsed_next = elapsed_inc;
              if (wait_over) phase_next = srs_pkg::PH_SET_PUSH;
            end
            srs_pkg::PH_SET_PUSH: begin
              wr_cur       = 1'b1;
              cur_val      = cfg.push_width;
              elapsed_next = '0;
              phase_next   = srs_pkg::PH_WAIT_HOLD;
            end
            srs_pkg::PH_WAIT_HOLD: begin
              elapsed_next = elapsed_inc;
              if (wait_over) phase_next = srs_pkg::PH_SET_END;
            end
            srs_pkg::PH_SET_END: begin
              wr_cur       = 1'b1;
              elapsed_next = '0;
              phase_next   = srs_pkg::PH_WAIT_END;
            end
            srs_pkg::PH_WAIT_END: begin
              elapsed_next = elapsed_inc;
              if (wait_over) begin
                done_next = done_inc;
                if (done_inc < tgt_sel) phase_next = srs_pkg::PH_SET_REST;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_MOTORS; k++) begin
      widths_next[k] = widths[k];
      if (wr_cur && SEL_BITS'(k) == sel) widths_next[k] = cur_val;
      if (wr_alt && SEL_BITS'(k) == alt_idx) widths_next[k] = cfg.rest_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      sel     <= '0;
      phase   <= srs_pkg::PH_SET_REST;
      elapsed <= '0;
      done    <= '0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        target[k] <= '0;
        widths[k] <= srs_pkg::STARTUP_WIDTH;
      end
    end else begin
      running <= running_next;
      sel     <= sel_next;
      phase   <= phase_next;
      elapsed <= elapsed_next;
      done    <= done_next;
      target  <= target_next;
      widths  <= widths_next;
    end
  end

  for (genvar g = 0; g < srs_pkg::IN_COUNTS; g++) begin : g_wout
    if (g < NUM_MOTORS) begin : g_have
      assign wout[g] = widths_next[g];
    end else begin : g_zero
      assign wout[g] = '0;
    end
  end

  assign res.width_one   = wout[0];
  assign res.width_two   = wout[1];
  assign res.width_three = wout[2];
  assign res.busy_res    = running_next;
  assign res.motor_now   = 2'(sel_next);
  assign res.reps_done   = 8'(done_next);

  `SRS_ASSERT_IMPL(a_sel_range, clk, rst, 1'b1, sel < NUM_MOTORS)
  `SRS_ASSERT_IMPL(a_done_bound, clk, rst, running, tgt_sel != '0 && done <= tgt_sel)
  `SRS_ASSERT_NEXT(a_idle_tick, clk, rst, step && item.op == srs_pkg::OP_TICK && !running, !running && $stable(sel) && $stable(done))

endmodule
